@@ design/sdcd_pkg.sv @@
// Shared types, register codes and reset values for the serial drive command deframer.
package sdcd_pkg;

  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_DELIMITER = 3'd0,
    CFG_ANGLE_BASE      = 3'd1,
    CFG_SPEED_BASE      = 3'd2,
    CFG_SPEED_LIMIT     = 3'd3,
    CFG_SPEED_SHIFT     = 3'd4,
    CFG_START_WORD      = 3'd5,
    CFG_STOP_WORD       = 3'd6
  } cfg_index_e;

  // Kind of result reported on the output channel.
  typedef enum logic [1:0] {
    EV_DRIVE   = 2'd0,
    EV_STARTED = 2'd1,
    EV_STOPPED = 2'd2
  } event_kind_e;

  localparam logic [7:0]  FRAME_DELIMITER_RST = 8'd13;
  localparam logic [15:0] ANGLE_BASE_RST      = 16'd1398;
  localparam logic [15:0] SPEED_BASE_RST      = 16'd3000;
  localparam logic [15:0] SPEED_LIMIT_RST     = 16'd7000;
  localparam logic [3:0]  SPEED_SHIFT_RST     = 4'd4;
  localparam logic [47:0] START_WORD_RST      = 48'd126943688291338;
  localparam logic [39:0] STOP_WORD_RST       = 40'd495874699274;

  localparam int START_WORD_MAX_W = 48;
  localparam int STOP_WORD_MAX_W  = 40;

  // Frame path settings.
  typedef struct packed {
    logic [7:0]  frame_delimiter;
    logic [15:0] angle_base;
    logic [15:0] speed_base;
    logic [15:0] speed_limit;
    logic [3:0]  speed_shift;
  } frame_cfg_t;

  // Decoded command for the byte now in process.
  typedef struct packed {
    logic        hit;
    logic [15:0] steer;
    logic [15:0] throttle;
    logic        forward;
  } frame_cmd_t;

  // Byte number sel of a keyword, byte 0 holding the last character.
  function automatic logic [7:0] key_byte(logic [63:0] word, logic [2:0] sel);
    return word[{sel, 3'b000} +: 8];
  endfunction

endpackage

@@ design/sdcd_keymatch.sv @@
// Keyword matcher: tracks progress through a keyword one byte at a time.
module sdcd_keymatch #(
  parameter int LEN    = 6,
  parameter int WORD_W = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              clr_i,
  input  logic [7:0]        byte_i,
  input  logic [WORD_W-1:0] word_i,
  output logic              hit_o
);
  import sdcd_pkg::*;

  localparam int PW = (LEN > 1) ? $clog2(LEN) : 1;

  logic [PW-1:0] prog_q, prog_d;
  logic [PW-1:0] p_eff;
  logic [PW:0]   p_inc;
  logic [63:0]   word64;
  logic [2:0]    sel_cur;
  logic [2:0]    sel_first;
  logic          cur_eq;
  logic          first_eq;

  assign word64    = 64'(word_i);
  assign p_eff     = (int'(prog_q) >= LEN) ? '0 : prog_q;
  assign sel_cur   = 3'(LEN - 1) - 3'(p_eff);
  assign sel_first = 3'(LEN - 1);
  assign cur_eq    = (byte_i == key_byte(word64, sel_cur));
  assign first_eq  = (byte_i == key_byte(word64, sel_first));
  assign p_inc     = {1'b0, p_eff} + (PW+1)'(1);
  assign hit_o     = cur_eq && (int'(p_inc) >= LEN);

  always_comb begin
    prog_d = prog_q;
    if (clr_i) begin
      prog_d = '0;
    end else if (en_i) begin
      if (cur_eq) begin
        prog_d = hit_o ? '0 : p_inc[PW-1:0];
      end else begin
        // recheck a mismatching byte against the first character
        prog_d = first_eq ? PW'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q <= '0;
    end else begin
      prog_q <= prog_d;
    end
  end

endmodule

@@ design/sdcd_frame.sv @@
// Frame window: holds the last four bytes and decodes a drive command.
module sdcd_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               clr_i,
  input  logic [7:0]         byte_i,
  input  sdcd_pkg::frame_cfg_t cfg_i,
  output sdcd_pkg::frame_cmd_t cmd_o
);
  import sdcd_pkg::*;

  localparam logic [2:0] FILL_FULL = 3'd4;

  logic [7:0]  recent_q [4];
  logic [2:0]  fill_q;
  logic [23:0] spd_shifted;
  logic [23:0] t_sum;
  logic [23:0] t_lim;

  assign spd_shifted = 24'(recent_q[1]) << cfg_i.speed_shift;
  assign t_sum       = 24'(cfg_i.speed_base) + spd_shifted;
  assign t_lim       = (t_sum >= 24'(cfg_i.speed_limit)) ?
                       t_sum - 24'(cfg_i.speed_limit) : t_sum;

  always_comb begin
    cmd_o.hit      = (fill_q == FILL_FULL)
                  && (recent_q[3] == (recent_q[0] | recent_q[1] | recent_q[2]))
                  && (byte_i == cfg_i.frame_delimiter);
    cmd_o.steer    = cfg_i.angle_base + 16'(recent_q[0]);
    cmd_o.throttle = t_lim[15:0];
    cmd_o.forward  = (recent_q[2] != 8'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        recent_q[i] <= '0;
      end
      fill_q <= '0;
    end else if (clr_i) begin
      for (int i = 0; i < 4; i++) begin
        recent_q[i] <= '0;
      end
      fill_q <= '0;
    end else if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        recent_q[i] <= recent_q[i+1];
      end
      recent_q[3] <= byte_i;
      if (fill_q != FILL_FULL) begin
        fill_q <= fill_q + 3'd1;
      end
    end
  end

endmodule

@@ design/serial_drive_command_deframer.sv @@
// Top level of the serial drive command deframer.
//
// Takes one received serial byte per transaction and reports at most one
// event per byte. While idle it watches for the start keyword and reports
// "started" when it completes; while running it watches for the stop
// keyword ("stopped") and slides a five-byte window over the stream,
// reporting a drive command for every frame of angle, speed, direction,
// check (OR of the first three) and delimiter. A stop keyword ending on the
// same byte as a frame wins. Throughput is one byte per clock unless the
// result register is held: each byte is held in an input register, then
// one pass of keyword compare, window shift and the throttle
// add/limit-subtract loads the result register.
// The output register lets a new byte enter while a result still waits.
// Configuration writes are always ready and must only be issued while idle.
module serial_drive_command_deframer #(
  parameter int START_WORD_LEN = 6,
  parameter int STOP_WORD_LEN  = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        rx_byte_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        event_kind_o,
  output logic [15:0]                       steer_compare_o,
  output logic [15:0]                       throttle_compare_o,
  output logic                              forward_o,
  output logic                              running_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sdcd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [sdcd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sdcd_pkg::*;

  // Only the keyword bytes that can be addressed are stored.
  localparam int START_W = (8*START_WORD_LEN < START_WORD_MAX_W) ?
                           8*START_WORD_LEN : START_WORD_MAX_W;
  localparam int STOP_W  = (8*STOP_WORD_LEN < STOP_WORD_MAX_W) ?
                           8*STOP_WORD_LEN : STOP_WORD_MAX_W;

  // Configuration registers
  frame_cfg_t          fcfg_q;
  logic [START_W-1:0]  start_word_q;
  logic [STOP_W-1:0]   stop_word_q;

  // Input register
  logic        in_valid_q;
  logic [7:0]  in_byte_q;

  // Run flag
  logic        run_q, run_d;

  // Result register
  logic        out_valid_q, out_valid_d;
  event_kind_e kind_q, kind_d;
  logic [15:0] steer_q, steer_d;
  logic [15:0] throttle_q, throttle_d;
  logic        forward_q, forward_d;
  logic        running_q, running_d;

  logic        advance;
  logic        proc;
  logic        start_hit;
  logic        stop_hit;
  logic        mode_flip;
  logic        fire;
  frame_cmd_t  cmd;

  // Configuration write port: always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcfg_q.frame_delimiter <= FRAME_DELIMITER_RST;
      fcfg_q.angle_base      <= ANGLE_BASE_RST;
      fcfg_q.speed_base      <= SPEED_BASE_RST;
      fcfg_q.speed_limit     <= SPEED_LIMIT_RST;
      fcfg_q.speed_shift     <= SPEED_SHIFT_RST;
      start_word_q           <= START_WORD_RST[START_W-1:0];
      stop_word_q            <= STOP_WORD_RST[STOP_W-1:0];
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_DELIMITER: fcfg_q.frame_delimiter <= cfg_data_i[7:0];
        CFG_ANGLE_BASE:      fcfg_q.angle_base      <= cfg_data_i[15:0];
        CFG_SPEED_BASE:      fcfg_q.speed_base      <= cfg_data_i[15:0];
        CFG_SPEED_LIMIT:     fcfg_q.speed_limit     <= cfg_data_i[15:0];
        CFG_SPEED_SHIFT:     fcfg_q.speed_shift     <= cfg_data_i[3:0];
        CFG_START_WORD:      start_word_q           <= cfg_data_i[START_W-1:0];
        CFG_STOP_WORD:       stop_word_q            <= cfg_data_i[STOP_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // The processing stage moves whenever the result register is free or
  // being taken this cycle.
  assign advance    = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register: load on accept, drain once processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Keyword matchers: start runs while idle, stop while running.
  sdcd_keymatch #(
    .LEN    (START_WORD_LEN),
    .WORD_W (START_W)
  ) u_start_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc && !run_q),
    .clr_i  (mode_flip),
    .byte_i (in_byte_q),
    .word_i (start_word_q),
    .hit_o  (start_hit)
  );

  sdcd_keymatch #(
    .LEN    (STOP_WORD_LEN),
    .WORD_W (STOP_W)
  ) u_stop_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc && run_q),
    .clr_i  (mode_flip),
    .byte_i (in_byte_q),
    .word_i (stop_word_q),
    .hit_o  (stop_hit)
  );

  // Frame window sees only bytes taken while running.
  sdcd_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc && run_q),
    .clr_i  (mode_flip),
    .byte_i (in_byte_q),
    .cfg_i  (fcfg_q),
    .cmd_o  (cmd)
  );

  // Entering run or idle clears both matchers and the window.
  assign mode_flip = proc && (run_q ? stop_hit : start_hit);
  assign fire      = proc && (mode_flip || (run_q && cmd.hit));

  always_comb begin
    run_d       = run_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    steer_d     = steer_q;
    throttle_d  = throttle_q;
    forward_d   = forward_q;
    running_d   = running_q;
    if (advance) begin
      out_valid_d = fire;
      if (proc) begin
        if (!run_q) begin
          if (start_hit) begin
            run_d      = 1'b1;
            kind_d     = EV_STARTED;
            steer_d    = '0;
            throttle_d = '0;
            forward_d  = 1'b0;
            running_d  = 1'b1;
          end
        end else if (stop_hit) begin
          // stop wins over a frame ending on the same byte
          run_d      = 1'b0;
          kind_d     = EV_STOPPED;
          steer_d    = '0;
          throttle_d = '0;
          forward_d  = 1'b0;
          running_d  = 1'b0;
        end else if (cmd.hit) begin
          kind_d     = EV_DRIVE;
          steer_d    = cmd.steer;
          throttle_d = cmd.throttle;
          forward_d  = cmd.forward;
          running_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    steer_q    <= steer_d;
    throttle_q <= throttle_d;
    forward_q  <= forward_d;
    running_q  <= running_d;
  end

  assign out_valid_o        = out_valid_q;
  assign event_kind_o       = kind_q;
  assign steer_compare_o    = steer_q;
  assign throttle_compare_o = throttle_q;
  assign forward_o          = forward_q;
  assign running_o          = running_q;

  // The run flag changes only on a byte that also reports an event.
  a_run_change_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(run_q) |-> $past(fire))
    else $error("run flag changed without a reported event");

  // A reported event leaves the run flag equal to its running field.
  a_running_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (running_q == run_q))
    else $error("running field disagrees with run flag");

  // Start and stop events carry zero command fields.
  a_event_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_kind_o == EV_STARTED || event_kind_o == EV_STOPPED))
      |-> (steer_compare_o == 16'd0 && throttle_compare_o == 16'd0 && !forward_o))
    else $error("start or stop event with nonzero command fields");

  // The input side stalls only while the result register is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register could move");

endmodule
